/* sv/irpl_pkg.sv */
// shared types and constants of the sensor linearizer
package irpl_pkg;

    localparam int SENSOR_W  = 3;
    localparam int ENTRY_W   = 3;
    localparam int VALUE_W   = 16;
    localparam int DIST_W    = 16;
    localparam int SEG_W     = 3;
    localparam int DIST_FRAC = 12;
    localparam int QUOT_W    = 17;
    localparam int OVF_SHIFT = QUOT_W - DIST_FRAC;
    localparam int CNT_W     = $clog2(QUOT_W + 1);
    localparam int SUM_W     = QUOT_W + 1;

    localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'(8 << DIST_FRAC);

    typedef enum logic
    {
        REQ_WRITE   = 1'b0,
        REQ_CONVERT = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        req_kind_t           kind;
        logic                sensor_ok;
        logic [SENSOR_W-1:0] sensor;
        logic [ENTRY_W-1:0]  entry;
        logic [VALUE_W-1:0]  value;
    } irpl_req_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_SETUP,
        BK_DIVIDE,
        BK_FINISH
    } back_state_t;

endpackage

/* sv/irpl_ram.sv */
// generic single-write, single-read ram with registered read data
module irpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/irpl_front.sv */
// front end: accepts requests, drops out-of-range writes, two-entry queue
module irpl_front #(
    parameter int SENSOR_COUNT = 8,
    parameter int STEP_COUNT   = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [irpl_pkg::SENSOR_W-1:0]   sensor_id,
    input  logic [irpl_pkg::ENTRY_W-1:0]    entry_index,
    input  logic [irpl_pkg::VALUE_W-1:0]    calib_value,
    input  logic [irpl_pkg::VALUE_W-1:0]    sample_value,
    output logic                            req_valid,
    output irpl_pkg::irpl_req_t             req,
    input  logic                            req_pop
);

    import irpl_pkg::*;

    irpl_req_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    irpl_req_t  incoming;
    logic       sensor_ok;
    logic       entry_ok;
    logic       accept;
    logic       push;
    logic       pop;

    assign sensor_ok = 5'(sensor_id) < 5'(SENSOR_COUNT);
    assign entry_ok  = 5'(entry_index) < 5'(STEP_COUNT);

    always_comb
    begin
        incoming.kind      = req_kind_t'(func);
        incoming.sensor_ok = sensor_ok;
        incoming.sensor    = sensor_id;
        incoming.entry     = entry_index;
        incoming.value     = func ? sample_value : calib_value;
    end

    assign in_ready  = count_reg != 2'd2;
    assign accept    = in_valid && in_ready;
    // writes outside the table are taken and dropped
    assign push      = accept && (func || (sensor_ok && entry_ok));
    assign req_valid = count_reg != 2'd0;
    assign req       = slot_reg[rd_ptr_reg];
    assign pop       = req_pop && req_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

/* sv/irpl_div.sv */
// serial restoring divider, one quotient bit per cycle, dividend scaled by 2^12
module irpl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [irpl_pkg::VALUE_W-1:0]  dividend,
    input  logic [irpl_pkg::VALUE_W-1:0]  divisor,
    output logic                          done,
    output logic [irpl_pkg::QUOT_W-1:0]   quotient
);

    import irpl_pkg::*;

    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic [QUOT_W-1:0]  low_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [VALUE_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [VALUE_W:0]   trial;
    logic               fits;

    assign trial    = {rem_reg, low_reg[QUOT_W-1]};
    assign fits     = trial >= {1'b0, div_reg};
    assign rem_next = fits ? VALUE_W'(trial - {1'b0, div_reg}) : trial[VALUE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(QUOT_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {{OVF_SHIFT{1'b0}}, dividend[VALUE_W-1:OVF_SHIFT]};
            low_reg  <= {dividend[OVF_SHIFT-1:0], {DIST_FRAC{1'b0}}};
            div_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* sv/irpl_back.sv */
// back end: table writes, segment scan, interpolation and result register
module irpl_back #(
    parameter int SENSOR_COUNT = 8,
    parameter int STEP_COUNT   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  irpl_pkg::irpl_req_t            req,
    output logic                           req_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [irpl_pkg::SENSOR_W-1:0]  out_sensor,
    output logic [irpl_pkg::DIST_W-1:0]    distance,
    output logic [irpl_pkg::SEG_W-1:0]     segment,
    output logic                           clamped,
    output logic                           degenerate
);

    import irpl_pkg::*;

    localparam int DEPTH  = SENSOR_COUNT * STEP_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int J_W    = $clog2(STEP_COUNT);
    localparam logic [J_W-1:0] LAST_J = J_W'(STEP_COUNT - 1);

    back_state_t state_reg;
    back_state_t state_next;

    irpl_req_t          cur_reg;
    logic [J_W-1:0]     j_reg;
    logic [J_W-1:0]     k_reg;
    logic [VALUE_W-1:0] lo_reg;
    logic [VALUE_W-1:0] hi_reg;
    logic               neg_reg;
    logic               ovf_reg;
    logic               degen_reg;

    logic               out_valid_reg;
    logic [SENSOR_W-1:0] out_sensor_reg;
    logic [DIST_W-1:0]  distance_reg;
    logic [SEG_W-1:0]   segment_reg;
    logic               clamped_reg;
    logic               degenerate_reg;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic [VALUE_W-1:0] entry_val;
    logic               seg_hit;

    logic [VALUE_W:0]   num;
    logic [VALUE_W:0]   den;
    logic [VALUE_W-1:0] num_mag;
    logic [VALUE_W-1:0] den_mag;
    logic               den_zero;
    logic               quot_ovf;
    logic               div_start;
    logic               div_done;
    logic [QUOT_W-1:0]  quot;

    logic               out_load;
    logic [SUM_W-1:0]   kval;
    logic [SUM_W-1:0]   sum;
    logic [DIST_W-1:0]  res_dist;
    logic               res_clamp;

    irpl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    irpl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (quot)
    );

    assign ram_waddr = ADDR_W'(int'(req.sensor) * STEP_COUNT + int'(req.entry));
    assign ram_raddr = cur_reg.sensor_ok
                     ? ADDR_W'(int'(cur_reg.sensor) * STEP_COUNT + int'(j_reg))
                     : '0;
    // rows of absent sensors read as zero
    assign entry_val = cur_reg.sensor_ok ? ram_rdata : '0;
    assign seg_hit   = (entry_val <= cur_reg.value) || (j_reg == LAST_J);

    assign num      = {1'b0, cur_reg.value} - {1'b0, lo_reg};
    assign den      = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign num_mag  = num[VALUE_W] ? VALUE_W'(-num) : num[VALUE_W-1:0];
    assign den_mag  = den[VALUE_W] ? VALUE_W'(-den) : den[VALUE_W-1:0];
    assign den_zero = den == '0;
    // quotient of 2^17 or more saturates either way
    assign quot_ovf = {{OVF_SHIFT{1'b0}}, num_mag} >= {den_mag, {OVF_SHIFT{1'b0}}};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (req_valid && req.kind == REQ_CONVERT)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                if (j_reg != '0 && seg_hit)
                begin
                    state_next = BK_SETUP;
                end
                else
                begin
                    state_next = BK_READ;
                end
            end
            BK_SETUP:
            begin
                if (den_zero || quot_ovf)
                begin
                    state_next = BK_FINISH;
                end
                else
                begin
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                req_pop = req_valid;
                ram_we  = req_valid && req.kind == REQ_WRITE;
            end
            BK_READ:
            begin
                ram_re = 1'b1;
            end
            BK_SETUP:
            begin
                div_start = !den_zero && !quot_ovf;
            end
            BK_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                req_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        kval      = SUM_W'(k_reg) << DIST_FRAC;
        sum       = kval + SUM_W'(quot);
        res_dist  = '0;
        res_clamp = 1'b0;
        if (degen_reg)
        begin
            res_clamp = kval > DIST_MAX;
            res_dist  = res_clamp ? DIST_W'(DIST_MAX) : DIST_W'(kval);
        end
        else if (ovf_reg)
        begin
            res_clamp = 1'b1;
            res_dist  = neg_reg ? '0 : DIST_W'(DIST_MAX);
        end
        else if (neg_reg)
        begin
            res_clamp = SUM_W'(quot) > kval;
            res_dist  = res_clamp ? '0 : DIST_W'(kval - SUM_W'(quot));
        end
        else
        begin
            res_clamp = sum > DIST_MAX;
            res_dist  = res_clamp ? DIST_W'(DIST_MAX) : DIST_W'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                cur_reg <= req;
                j_reg   <= '0;
            end
            BK_CHECK:
            begin
                if (j_reg == '0)
                begin
                    lo_reg <= entry_val;
                    j_reg  <= J_W'(j_reg + 1'b1);
                end
                else if (seg_hit)
                begin
                    hi_reg <= entry_val;
                    k_reg  <= J_W'(j_reg - 1'b1);
                end
                else
                begin
                    lo_reg <= entry_val;
                    j_reg  <= J_W'(j_reg + 1'b1);
                end
            end
            BK_SETUP:
            begin
                degen_reg <= den_zero;
                ovf_reg   <= quot_ovf;
                neg_reg   <= num[VALUE_W] != den[VALUE_W];
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
        if (out_load)
        begin
            out_sensor_reg <= cur_reg.sensor;
            distance_reg   <= res_dist;
            segment_reg    <= SEG_W'(k_reg);
            clamped_reg    <= res_clamp;
            degenerate_reg <= degen_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sensor = out_sensor_reg;
    assign distance   = distance_reg;
    assign segment    = segment_reg;
    assign clamped    = clamped_reg;
    assign degenerate = degenerate_reg;

endmodule

/* sv/ir_sensor_piecewise_linearizer.sv */
// top level of the proximity sensor piecewise-linear distance converter
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | func, sensor_id, entry_index, calib_value,
//          |                      | sample_value
//  out     | out_valid/ out_ready | out_sensor, distance, segment, clamped,
//          |                      | degenerate
//
// a write request gives no result
// a convert scans the table to find segment k, then runs the serial divider (17 quotient
// bits, one per cycle) unless degenerate or saturated; the table ram has one read port
// reset clears the queue and sequencer only; table contents stay unknown until written
// the two-entry queue takes new requests while the back end works or its output stalls
module ir_sensor_piecewise_linearizer #(
    parameter int SENSOR_COUNT = 8,
    parameter int STEP_COUNT   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [irpl_pkg::SENSOR_W-1:0]  sensor_id,
    input  logic [irpl_pkg::ENTRY_W-1:0]   entry_index,
    input  logic [irpl_pkg::VALUE_W-1:0]   calib_value,
    input  logic [irpl_pkg::VALUE_W-1:0]   sample_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [irpl_pkg::SENSOR_W-1:0]  out_sensor,
    output logic [irpl_pkg::DIST_W-1:0]    distance,
    output logic [irpl_pkg::SEG_W-1:0]     segment,
    output logic                           clamped,
    output logic                           degenerate
);

    import irpl_pkg::*;

    logic      req_valid;
    logic      req_pop;
    irpl_req_t req;

    irpl_front #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .STEP_COUNT   (STEP_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .sensor_id    (sensor_id),
        .entry_index  (entry_index),
        .calib_value  (calib_value),
        .sample_value (sample_value),
        .req_valid    (req_valid),
        .req          (req),
        .req_pop      (req_pop)
    );

    irpl_back #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .STEP_COUNT   (STEP_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .req_pop    (req_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sensor (out_sensor),
        .distance   (distance),
        .segment    (segment),
        .clamped    (clamped),
        .degenerate (degenerate)
    );

endmodule

/* sv/irpl_checker.sv */
// port-level assertions for the linearizer, bound to the top level
module irpl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [irpl_pkg::SENSOR_W-1:0]  out_sensor,
    input logic [irpl_pkg::DIST_W-1:0]    distance,
    input logic [irpl_pkg::SEG_W-1:0]     segment,
    input logic                           clamped,
    input logic                           degenerate
);

    import irpl_pkg::*;

    localparam logic [DIST_W-1:0] DIST_TOP = DIST_W'(DIST_MAX);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(distance) && $stable(out_sensor)
            && $stable(segment) && $stable(clamped) && $stable(degenerate))
        else $error("result changed while stalled");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance <= DIST_TOP)
        else $error("distance above full scale");

    a_clamp_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> distance == '0 || distance == DIST_TOP)
        else $error("clamped result not at a limit");

    a_degen_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> distance[DIST_FRAC-1:0] == '0)
        else $error("degenerate result has a fraction");

endmodule

bind ir_sensor_piecewise_linearizer irpl_checker u_irpl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sensor (out_sensor),
    .distance   (distance),
    .segment    (segment),
    .clamped    (clamped),
    .degenerate (degenerate)
);
